>>> rtl/dpbp_pkg.sv
// ----------------------------------------------------------------------------
// Depth pixel back-projection package
// Shared widths, configuration register indexes, reset values and the
// stage-advance bundle passed from the top level to the axis datapaths.
// ----------------------------------------------------------------------------
package dpbp_pkg;

  // Field widths
  localparam int unsigned PixW   = 12;
  localparam int unsigned DepthW = 16;
  localparam int unsigned ColorW = 8;
  localparam int unsigned HalfW  = 13;  // half-pixel offsets and principal points
  localparam int unsigned ScaleW = 32;  // Q0.32 coefficients
  localparam int unsigned ZW     = 31;  // unsigned Q15.16 distance
  localparam int unsigned PosW   = 32;  // signed Q16.16 coordinates
  localparam int unsigned CfgIdxW = 3;

  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 120;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEPTH_SCALE = 3'd0,
    CFG_CX_HALF     = 3'd1,
    CFG_CY_HALF     = 3'd2,
    CFG_INV_FX      = 3'd3,
    CFG_INV_FY      = 3'd4
  } cfg_idx_e;

  // Register values after reset
  localparam logic [ScaleW-1:0] DepthScaleRst = 32'd4294967;
  localparam logic [HalfW-1:0]  CxHalfRst     = 13'd651;
  localparam logic [HalfW-1:0]  CyHalfRst     = 13'd507;
  localparam logic [ScaleW-1:0] InvFxRst      = 32'd8291634;
  localparam logic [ScaleW-1:0] InvFyRst      = 32'd8275659;

  // Load enables for pipeline stages 3 to 6
  typedef struct packed {
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } adv_t;

endpackage

>>> rtl/dpbp_axis.sv
// ----------------------------------------------------------------------------
// Depth pixel back-projection axis datapath
// Scales a signed half-pixel offset by z and a Q0.32 reciprocal focal length,
// floors by 2^33 and saturates to a signed Q16.16 coordinate (stages 3 to 6).
// ----------------------------------------------------------------------------
module dpbp_axis (
  input  logic                         clk_i,
  input  dpbp_pkg::adv_t               adv_i,
  input  logic [dpbp_pkg::HalfW-1:0]   mag_i,   // |2*pix - centre|, stage 2
  input  logic                         neg_i,   // offset is negative, stage 2
  input  logic [dpbp_pkg::ZW-1:0]      z_i,     // saturated z, stage 2
  input  logic [dpbp_pkg::ScaleW-1:0]  inv_i,   // reciprocal focal length
  output logic [dpbp_pkg::PosW-1:0]    pos_o    // coordinate, stage 6
);

  localparam int unsigned ProdW = dpbp_pkg::HalfW + dpbp_pkg::ZW;       // 44
  localparam int unsigned HiW   = ProdW - 32;                           // 12
  localparam int unsigned LoW   = 64;
  localparam int unsigned HiPW  = HiW + dpbp_pkg::ScaleW;               // 44
  localparam int unsigned TopW  = HiPW + 1;                             // 45

  logic [ProdW-1:0] prod_q;
  logic             neg3_q;
  logic [LoW-1:0]   lo_q;
  logic [HiPW-1:0]  hi_q;
  logic             neg4_q;
  logic [TopW-1:0]  top_q;
  logic             rem_q;
  logic             neg5_q;
  logic [dpbp_pkg::PosW-1:0] pos_q;

  logic [TopW-1:0]  top_d;
  logic [TopW-2:0]  quot;
  logic [TopW-1:0]  quot_up;
  logic [dpbp_pkg::PosW-1:0] neg_mag;
  logic [dpbp_pkg::PosW-1:0] pos_d;

  // Stage 3: offset magnitude times z
  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      prod_q <= ProdW'(mag_i) * ProdW'(z_i);
      neg3_q <= neg_i;
    end
  end

  // Stage 4: split the 44-bit product into two partial products with inv
  always_ff @(posedge clk_i) begin
    if (adv_i.s4) begin
      lo_q   <= LoW'(prod_q[31:0]) * LoW'(inv_i);
      hi_q   <= HiPW'(prod_q[ProdW-1:32]) * HiPW'(inv_i);
      neg4_q <= neg3_q;
    end
  end

  // Stage 5: recombine to the product shifted down by 32, keep the sticky bit
  assign top_d = {1'b0, hi_q} + TopW'(lo_q[LoW-1:32]);

  always_ff @(posedge clk_i) begin
    if (adv_i.s5) begin
      top_q  <= top_d;
      rem_q  <= (|lo_q[31:0]) | top_d[0];
      neg5_q <= neg4_q;
    end
  end

  // Stage 6: floor, saturate and apply the sign
  assign quot    = top_q[TopW-1:1];
  assign quot_up = {1'b0, quot} + TopW'(rem_q);

  always_comb begin
    if (quot_up > TopW'(33'h0_8000_0000)) begin
      neg_mag = 32'h8000_0000;
    end else begin
      neg_mag = quot_up[dpbp_pkg::PosW-1:0];
    end
    if (neg5_q) begin
      pos_d = 32'd0 - neg_mag;
    end else if (|quot[TopW-2:31]) begin
      pos_d = 32'h7FFF_FFFF;
    end else begin
      pos_d = {1'b0, quot[30:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s6) begin
      pos_q <= pos_d;
    end
  end

  assign pos_o = pos_q;

endmodule

>>> rtl/depth_pixel_back_projection_unit.sv
// Pipeline: six register stages; the first loads on a pixel transfer, and
//   the last drives the point output port.
// Throughput: one pixel per cycle while m_axis_tready is high; each multiplier
//   feeds a register (depth scale, offset times z, 32x32 and 12x32 partials).
// A pixel with zero depth is taken and gives no result. Reset clears all stage
//   valid bits, loads the default camera registers and takes pixels at once.
// ----------------------------------------------------------------------------
// Depth pixel back-projection unit
// Turns a stream of depth pixels into points in metres (x, y signed Q16.16,
// z unsigned Q15.16) by a pinhole camera model; pixel colour passes alongside.
// ----------------------------------------------------------------------------
module depth_pixel_back_projection_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dpbp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [31:0]                     cfg_data_i,
  // Pixel stream in
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // col[11:0], row[23:12], depth_raw[39:24], blue_in[47:40],
  // green_in[55:48], red_in[63:56]
  input  logic [dpbp_pkg::InDataW-1:0]    s_axis_tdata,
  // Point stream out
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // x_pos[31:0], y_pos[63:32], z_pos[94:64], blue_out[102:95],
  // green_out[110:103], red_out[118:111], zero[119]
  output logic [dpbp_pkg::OutDataW-1:0]   m_axis_tdata
);

  localparam int unsigned ZFullW = dpbp_pkg::DepthW + dpbp_pkg::ScaleW;  // 48
  localparam int unsigned BgrW   = 3 * dpbp_pkg::ColorW;

  typedef struct packed {
    logic [dpbp_pkg::ZW-1:0] z;
    logic [BgrW-1:0]         bgr;
  } side_t;

  // Configuration registers
  logic [dpbp_pkg::ScaleW-1:0] depth_scale_q, inv_fx_q, inv_fy_q;
  logic [dpbp_pkg::HalfW-1:0]  cx_half_q, cy_half_q;

  // Input field unpack
  logic [dpbp_pkg::PixW-1:0]   in_col, in_row;
  logic [dpbp_pkg::DepthW-1:0] in_depth;
  logic [BgrW-1:0]             in_bgr;

  // Stage valid bits and ready chain
  logic [6:1] vld_q;
  logic [6:1] rdy;

  // Stage 1 and 2 payload
  logic [ZFullW-1:0]          zfull1_q;
  logic [dpbp_pkg::HalfW-1:0] magx1_q, magy1_q, magx2_q, magy2_q;
  logic                       negx1_q, negy1_q, negx2_q, negy2_q;
  logic [BgrW-1:0]            bgr1_q, bgr2_q;
  logic [dpbp_pkg::ZW-1:0]    z2_q;
  side_t                      side_q [3:6];

  logic [dpbp_pkg::HalfW-1:0] twice_col, twice_row;
  logic                       negx_d, negy_d;
  logic [dpbp_pkg::HalfW-1:0] magx_d, magy_d;
  logic [dpbp_pkg::ZW-1:0]    z2_d;

  dpbp_pkg::adv_t             adv;
  logic [dpbp_pkg::PosW-1:0]  x_pos, y_pos;

  assign in_col   = s_axis_tdata[11:0];
  assign in_row   = s_axis_tdata[23:12];
  assign in_depth = s_axis_tdata[39:24];
  assign in_bgr   = s_axis_tdata[63:40];

  // Take every configuration write
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_scale_q <= dpbp_pkg::DepthScaleRst;
      cx_half_q     <= dpbp_pkg::CxHalfRst;
      cy_half_q     <= dpbp_pkg::CyHalfRst;
      inv_fx_q      <= dpbp_pkg::InvFxRst;
      inv_fy_q      <= dpbp_pkg::InvFyRst;
    end else if (cfg_valid_i) begin
      case (dpbp_pkg::cfg_idx_e'(cfg_index_i))
        dpbp_pkg::CFG_DEPTH_SCALE: depth_scale_q <= cfg_data_i;
        dpbp_pkg::CFG_CX_HALF:     cx_half_q     <= cfg_data_i[dpbp_pkg::HalfW-1:0];
        dpbp_pkg::CFG_CY_HALF:     cy_half_q     <= cfg_data_i[dpbp_pkg::HalfW-1:0];
        dpbp_pkg::CFG_INV_FX:      inv_fx_q      <= cfg_data_i;
        dpbp_pkg::CFG_INV_FY:      inv_fy_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or the next one loads
  always_comb begin
    rdy[6] = !vld_q[6] || m_axis_tready;
    for (int k = 5; k >= 1; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[1];
  assign adv = '{s3: rdy[3], s4: rdy[4], s5: rdy[5], s6: rdy[6]};

  // Advance valid bits; drop zero-depth pixels at entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[1]) begin
        vld_q[1] <= s_axis_tvalid && (in_depth != '0);
      end
      for (int k = 2; k <= 6; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage 1: depth times scale, signed half-pixel offsets
  assign twice_col = {in_col, 1'b0};
  assign twice_row = {in_row, 1'b0};
  assign negx_d    = cx_half_q > twice_col;
  assign negy_d    = cy_half_q > twice_row;
  assign magx_d    = negx_d ? (cx_half_q - twice_col) : (twice_col - cx_half_q);
  assign magy_d    = negy_d ? (cy_half_q - twice_row) : (twice_row - cy_half_q);

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      zfull1_q <= ZFullW'(in_depth) * ZFullW'(depth_scale_q);
      magx1_q  <= magx_d;
      negx1_q  <= negx_d;
      magy1_q  <= magy_d;
      negy1_q  <= negy_d;
      bgr1_q   <= in_bgr;
    end
  end

  // Stage 2: shift down by 16 and saturate z
  assign z2_d = zfull1_q[ZFullW-1] ? '1 : zfull1_q[ZFullW-2:16];

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      z2_q    <= z2_d;
      magx2_q <= magx1_q;
      negx2_q <= negx1_q;
      magy2_q <= magy1_q;
      negy2_q <= negy1_q;
      bgr2_q  <= bgr1_q;
    end
  end

  // Stages 3 to 6: carry z and colour beside the axis datapaths
  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      side_q[3] <= '{z: z2_q, bgr: bgr2_q};
    end
    for (int k = 4; k <= 6; k++) begin
      if (rdy[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  dpbp_axis u_axis_x (
    .clk_i (clk_i),
    .adv_i (adv),
    .mag_i (magx2_q),
    .neg_i (negx2_q),
    .z_i   (z2_q),
    .inv_i (inv_fx_q),
    .pos_o (x_pos)
  );

  dpbp_axis u_axis_y (
    .clk_i (clk_i),
    .adv_i (adv),
    .mag_i (magy2_q),
    .neg_i (negy2_q),
    .z_i   (z2_q),
    .inv_i (inv_fy_q),
    .pos_o (y_pos)
  );

  // Output port straight from the last stage
  assign m_axis_tvalid = vld_q[6];
  assign m_axis_tdata  = {1'b0, side_q[6].bgr, side_q[6].z, y_pos, x_pos};

endmodule

>>> rtl/dpbp_checker.sv
// ----------------------------------------------------------------------------
// Depth pixel back-projection port checker
// Watches the top-level ports for stall, ready and point consistency rules.
// ----------------------------------------------------------------------------
module dpbp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [dpbp_pkg::OutDataW-1:0] m_axis_tdata
);

  // Hold a stalled result unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or vanished");

  // A free output side always frees the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output side is ready");

  // A point at zero distance lies on the optical axis
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[94:64] == '0) |->
      (m_axis_tdata[31:0] == '0) && (m_axis_tdata[63:32] == '0))
    else $error("nonzero x or y with zero z");

  // No result during reset
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind depth_pixel_back_projection_unit dpbp_checker u_dpbp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
